FILE: design/bti_pkg.sv
package bti_pkg;

	localparam int POINT_COUNT = 56;
	localparam int ADDR_W = $clog2(POINT_COUNT);
	localparam int VAL_W = 11;
	localparam int INDEX_W = 6;
	localparam int TENTHS_PER_DEG = 10;
	localparam int CURVE_LOW = -400;
	localparam int CURVE_HIGH = CURVE_LOW + (POINT_COUNT - 1) * TENTHS_PER_DEG;
	// offset above the lowest breakpoint, in tenths
	localparam int OFF_W = $clog2((POINT_COUNT - 1) * TENTHS_PER_DEG + 1);
	localparam int FRAC_W = 4;
	// floor(off / 10) == (off * 205) >> 11 for every off below 1029
	localparam int RECIP_SMALL = 205;
	localparam int RECIP_SMALL_SH = 11;
	localparam int RECIP_SMALL_W = 8;
	// floor(m / 10) == (m * 52429) >> 19 for every 16-bit product magnitude used here
	localparam int RECIP_BIG = 52429;
	localparam int RECIP_BIG_SH = 19;
	localparam int PROD_W = VAL_W + 1 + FRAC_W + 1;
	localparam int MAG_W = PROD_W - 1;
	localparam int QUOT_W = VAL_W + 1;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_EVAL  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADDR,
		ST_MUL,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic take_in;
		logic latch_addr;
		logic latch_prod;
		logic load_out;
	} ctl_t;

	typedef struct packed {
		logic out_blocked;
	} status_t;

endpackage

FILE: design/breakpoint_table_interpolator_unit.sv
// Evaluate: after the input transfer the sequencer loads the result, then takes the next item.
// The divide stage waits while an earlier result is still held up, which delays both.
// Write: one curve point per cycle while no evaluation is in flight, no result.
// The sequencer steps are address, table read and multiply, divide-by-ten.
// A finished result waits in the output register while the next item is taken.
// arst_n clears the sequencer and output valid; the curve memory holds no reset value.
module breakpoint_table_interpolator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             cmd,
	input  logic [bti_pkg::INDEX_W-1:0]      point_index,
	input  logic signed [bti_pkg::VAL_W-1:0] point_value,
	input  logic signed [bti_pkg::VAL_W-1:0] outdoor_tenths,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [bti_pkg::VAL_W-1:0] target_tenths,
	output logic                             on_breakpoint
);

	bti_pkg::ctl_t    ctl;
	bti_pkg::status_t st;

	bti_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.cmd     (cmd),
		.in_stall(in_stall),
		.ctl     (ctl),
		.st      (st)
	);

	bti_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.st            (st),
		.cmd           (cmd),
		.point_index   (point_index),
		.point_value   (point_value),
		.outdoor_tenths(outdoor_tenths),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.target_tenths (target_tenths),
		.on_breakpoint (on_breakpoint)
	);

endmodule

FILE: design/bti_ram.sv
module bti_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: design/bti_datapath.sv
module bti_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bti_pkg::ctl_t                         ctl,
	output bti_pkg::status_t                      st,
	input  logic                                  cmd,
	input  logic [bti_pkg::INDEX_W-1:0]           point_index,
	input  logic signed [bti_pkg::VAL_W-1:0]      point_value,
	input  logic signed [bti_pkg::VAL_W-1:0]      outdoor_tenths,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [bti_pkg::VAL_W-1:0]      target_tenths,
	output logic                                  on_breakpoint
);

	localparam logic signed [bti_pkg::VAL_W:0] LOW_C = (bti_pkg::VAL_W + 1)'(bti_pkg::CURVE_LOW);
	localparam logic signed [bti_pkg::VAL_W:0] HIGH_C =
		(bti_pkg::VAL_W + 1)'(bti_pkg::CURVE_HIGH);

	logic signed [bti_pkg::VAL_W-1:0] x_q;
	logic signed [bti_pkg::VAL_W:0]   x_ext;
	logic signed [bti_pkg::VAL_W:0]   x_clamp;
	logic signed [bti_pkg::VAL_W:0]   off_full;
	logic [bti_pkg::OFF_W-1:0]        off;
	logic [bti_pkg::OFF_W+bti_pkg::RECIP_SMALL_W-1:0] idx_mul;
	logic [bti_pkg::ADDR_W-1:0]       idx;
	logic [bti_pkg::OFF_W-1:0]        idx_times10;
	logic [bti_pkg::FRAC_W-1:0]       frac;
	logic [bti_pkg::ADDR_W-1:0]       raddr_hi;
	logic                             we;
	logic [bti_pkg::VAL_W-1:0]        lo_raw;
	logic [bti_pkg::VAL_W-1:0]        hi_raw;

	logic [bti_pkg::FRAC_W-1:0]       frac_s1;
	logic                             exact_s1;

	logic signed [bti_pkg::VAL_W:0]   diff;
	logic signed [bti_pkg::PROD_W-1:0] prod;
	logic signed [bti_pkg::PROD_W-1:0] prod_s2;
	logic signed [bti_pkg::VAL_W-1:0] lo_s2;
	logic                             exact_s2;

	logic                             neg;
	logic [bti_pkg::MAG_W-1:0]        mag;
	logic [2*bti_pkg::MAG_W-1:0]      mag_mul;
	logic [bti_pkg::QUOT_W-1:0]       quot;
	logic signed [bti_pkg::QUOT_W:0]  quot_s;
	logic signed [bti_pkg::QUOT_W:0]  sum;

	logic                             out_valid_q;
	logic signed [bti_pkg::VAL_W-1:0] target_q;
	logic                             exact_q;

	assign we = ctl.take_in && (cmd == bti_pkg::CMD_WRITE)
		&& ({1'b0, point_index} < (bti_pkg::INDEX_W + 1)'(bti_pkg::POINT_COUNT));

	// clamp, then split into whole degrees and tenths
	always_comb begin
		x_ext = (bti_pkg::VAL_W + 1)'(x_q);
		if (x_ext < LOW_C) begin
			x_clamp = LOW_C;
		end else if (x_ext > HIGH_C) begin
			x_clamp = HIGH_C;
		end else begin
			x_clamp = x_ext;
		end
		off_full = x_clamp - LOW_C;
		off = off_full[bti_pkg::OFF_W-1:0];
		idx_mul = off * bti_pkg::RECIP_SMALL_W'(bti_pkg::RECIP_SMALL);
		idx = idx_mul[bti_pkg::RECIP_SMALL_SH +: bti_pkg::ADDR_W];
		idx_times10 = bti_pkg::OFF_W'(idx) * bti_pkg::OFF_W'(bti_pkg::TENTHS_PER_DEG);
		frac = bti_pkg::FRAC_W'(off - idx_times10);
		// on a breakpoint the upper read must stay inside the table
		raddr_hi = (frac == '0) ? idx : idx + bti_pkg::ADDR_W'(1);
	end

	bti_ram #(
		.WIDTH(bti_pkg::VAL_W),
		.DEPTH(bti_pkg::POINT_COUNT)
	) u_curve (
		.clk    (clk),
		.we     (we),
		.waddr  (bti_pkg::ADDR_W'(point_index)),
		.wdata  (point_value),
		.raddr_a(idx),
		.raddr_b(raddr_hi),
		.rdata_a(lo_raw),
		.rdata_b(hi_raw)
	);

	always_comb begin
		diff = (bti_pkg::VAL_W + 1)'(signed'(hi_raw)) - (bti_pkg::VAL_W + 1)'(signed'(lo_raw));
		prod = bti_pkg::PROD_W'(diff) * signed'(bti_pkg::PROD_W'(frac_s1));
	end

	// truncating divide by ten on the magnitude
	always_comb begin
		neg = prod_s2[bti_pkg::PROD_W-1];
		mag = neg ? bti_pkg::MAG_W'(-prod_s2) : bti_pkg::MAG_W'(prod_s2);
		mag_mul = mag * bti_pkg::MAG_W'(bti_pkg::RECIP_BIG);
		quot = mag_mul[bti_pkg::RECIP_BIG_SH +: bti_pkg::QUOT_W];
		quot_s = neg ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
		sum = (bti_pkg::QUOT_W + 1)'(lo_s2) + quot_s;
	end

	always_ff @(posedge clk) begin
		if (ctl.take_in) begin
			x_q <= outdoor_tenths;
		end
		if (ctl.latch_addr) begin
			frac_s1 <= frac;
			exact_s1 <= (frac == '0);
		end
		if (ctl.latch_prod) begin
			prod_s2 <= prod;
			lo_s2 <= signed'(lo_raw);
			exact_s2 <= exact_s1;
		end
		if (ctl.load_out) begin
			target_q <= sum[bti_pkg::VAL_W-1:0];
			exact_q <= exact_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign st.out_blocked = out_valid_q && out_stall;
	assign out_valid = out_valid_q;
	assign target_tenths = target_q;
	assign on_breakpoint = exact_q;

endmodule

FILE: design/bti_ctrl.sv
module bti_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             cmd,
	output logic             in_stall,
	output bti_pkg::ctl_t    ctl,
	input  bti_pkg::status_t st
);

	bti_pkg::state_t state_q;
	bti_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bti_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		in_stall = 1'b1;
		unique case (state_q)
			bti_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				ctl.take_in = in_valid;
				if (in_valid && cmd == bti_pkg::CMD_EVAL) begin
					state_d = bti_pkg::ST_ADDR;
				end
			end
			bti_pkg::ST_ADDR: begin
				ctl.latch_addr = 1'b1;
				state_d = bti_pkg::ST_MUL;
			end
			bti_pkg::ST_MUL: begin
				ctl.latch_prod = 1'b1;
				state_d = bti_pkg::ST_DIV;
			end
			bti_pkg::ST_DIV: begin
				// wait here while the previous result is still held up
				if (!st.out_blocked) begin
					ctl.load_out = 1'b1;
					state_d = bti_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bti_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: verif/tb_breakpoint_table_interpolator_unit.sv
module tb_breakpoint_table_interpolator_unit;
	import bti_pkg::*;

	typedef struct packed {
		cmd_t                      op;
		logic [INDEX_W-1:0]        index;
		logic signed [VAL_W-1:0]   value;
		logic signed [VAL_W-1:0]   outdoor;
	} curve_op_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]   target;
		logic                      exact;
	} target_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	cmd_t                    cmd = CMD_WRITE;
	logic [INDEX_W-1:0]      point_index = '0;
	logic signed [VAL_W-1:0] point_value = '0;
	logic signed [VAL_W-1:0] outdoor_tenths = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [VAL_W-1:0] target_tenths;
	logic                    on_breakpoint;

	curve_op_t               op_q[$];
	target_t                 target_q[$];
	logic signed [VAL_W-1:0] curve_model [POINT_COUNT];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int evals_checked = 0;
	int writes_taken = 0;
	int writes_ignored = 0;

	breakpoint_table_interpolator_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.point_index    (point_index),
		.point_value    (point_value),
		.outdoor_tenths (outdoor_tenths),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.target_tenths  (target_tenths),
		.on_breakpoint  (on_breakpoint)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// clamp, floor to the lower breakpoint, then blend towards the upper one
	function automatic target_t predict_target(logic signed [VAL_W-1:0] outdoor);
		target_t r;
		int x, off, seg, frac, lo, hi;
		x = outdoor;
		if (x < CURVE_LOW) x = CURVE_LOW;
		if (x > CURVE_HIGH) x = CURVE_HIGH;
		off = x - CURVE_LOW;
		seg = off / TENTHS_PER_DEG;
		frac = off % TENTHS_PER_DEG;
		lo = curve_model[seg];
		if (frac == 0) begin
			r.target = VAL_W'(lo);
			r.exact = 1'b1;
		end else begin
			hi = curve_model[seg + 1];
			r.target = VAL_W'(lo + ((hi - lo) * frac) / TENTHS_PER_DEG);
			r.exact = 1'b0;
		end
		return r;
	endfunction

	task automatic push_op(cmd_t op, int index, int value, int outdoor);
		curve_op_t c;
		c.op = op;
		c.index = INDEX_W'(index);
		c.value = VAL_W'(value);
		c.outdoor = VAL_W'(outdoor);
		op_q.push_back(c);
	endtask

	// sender held off until the block has nothing left in flight
	task automatic drain();
		while (op_q.size() != 0 || in_valid || target_q.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		curve_op_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= CMD_WRITE;
			point_index <= '0;
			point_value <= '0;
			outdoor_tenths <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				if (cmd == CMD_WRITE) begin
					writes_taken++;
					if (point_index < POINT_COUNT)
						curve_model[point_index] = point_value;
					else
						writes_ignored++;
				end else begin
					target_q.push_back(predict_target(outdoor_tenths));
				end
			end
			if (!in_valid || !in_stall) begin
				if (op_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = op_q.pop_front();
					in_valid <= 1'b1;
					cmd <= nxt.op;
					point_index <= nxt.index;
					point_value <= nxt.value;
					outdoor_tenths <= nxt.outdoor;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		target_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (target_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got target %0d exact %0b",
						$time, target_tenths, on_breakpoint);
				end else begin
					want = target_q.pop_front();
					evals_checked++;
					if (target_tenths !== want.target) begin
						errors++;
						$display("%0t: target_tenths expected %0d got %0d",
							$time, want.target, target_tenths);
					end
					if (on_breakpoint !== want.exact) begin
						errors++;
						$display("%0t: on_breakpoint expected %0b got %0b",
							$time, want.exact, on_breakpoint);
					end
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		int n, pick, outdoor;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// whole curve loaded first so no evaluation ever reads an unwritten point
		for (int i = 0; i < POINT_COUNT; i++)
			push_op(CMD_WRITE, i, $urandom, $urandom);

		// steepest rise at the bottom, steepest fall at the top
		push_op(CMD_WRITE, 0, -1024, 0);
		push_op(CMD_WRITE, 1, 1023, -1);
		push_op(CMD_WRITE, POINT_COUNT - 2, 1023, 0);
		push_op(CMD_WRITE, POINT_COUNT - 1, -1024, 0);
		// out of range indices, dropped by the block
		push_op(CMD_WRITE, POINT_COUNT, 5, 0);
		push_op(CMD_WRITE, 63, -7, 0);
		push_op(CMD_EVAL, 63, 0, -1024);
		push_op(CMD_EVAL, 0, -1, -1000);
		push_op(CMD_EVAL, 0, 0, -401);
		push_op(CMD_EVAL, 0, 0, CURVE_LOW);
		push_op(CMD_EVAL, 0, 0, -399);
		push_op(CMD_EVAL, 0, 0, -395);
		push_op(CMD_EVAL, 0, 0, -391);
		push_op(CMD_EVAL, 0, 0, -270);
		push_op(CMD_EVAL, 0, 0, -1);
		push_op(CMD_EVAL, 0, 0, 0);
		push_op(CMD_EVAL, 0, 0, CURVE_HIGH - 9);
		push_op(CMD_EVAL, 0, 0, CURVE_HIGH - 1);
		push_op(CMD_EVAL, 0, 0, CURVE_HIGH);
		push_op(CMD_EVAL, 0, 0, CURVE_HIGH + 1);
		push_op(CMD_EVAL, 0, 0, 1023);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 71; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 71; end
				default: begin send_idle_pct = 11; stall_pct = 11; end
			endcase
			n = 0;
			while (n < 255) begin
				if ($urandom_range(99) < 25) begin
					if ($urandom_range(9) == 0) begin
						push_op(CMD_WRITE, $urandom_range(63, POINT_COUNT), $urandom, $urandom);
					end else begin
						pick = $urandom_range(9);
						push_op(CMD_WRITE, $urandom_range(POINT_COUNT - 1),
							(pick == 0) ? -1024 : (pick == 1) ? 1023 : int'($urandom),
							$urandom);
						n++;
					end
				end else begin
					pick = $urandom_range(99);
					if (pick < 60)
						outdoor = CURVE_LOW + int'($urandom_range(CURVE_HIGH - CURVE_LOW));
					else if (pick < 75)
						outdoor = CURVE_LOW + TENTHS_PER_DEG * int'($urandom_range(POINT_COUNT - 1));
					else
						outdoor = $urandom;
					push_op(CMD_EVAL, $urandom, $urandom, outdoor);
					n++;
				end
			end
			drain();
		end

		$display("Checked %0d curve evaluations and %0d point writes (%0d dropped)",
			evals_checked, writes_taken, writes_ignored);
		$display("over free-running, sender-idle, receiver-stall and mixed handshake phases");
		if (errors == 0)
			$display("tb_breakpoint_table_interpolator_unit: clean");
		else
			$display("tb_breakpoint_table_interpolator_unit: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_breakpoint_table_interpolator_unit: errors");
		$finish;
	end

endmodule
